// File: sv/assert_macros.svh
// Assertion macros shared by the mouse report encoder RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/mre_pkg.sv
// Shared types and constants for the mouse report encoder.
// No dependencies; imported by every module of the block.
package mre_pkg;

  localparam int NUM_W = 13;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_X10 = 2'd1,
    MODE_SGR = 2'd2,
    MODE_RSV = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ESC,
    PH_LBRACKET,
    PH_LT,
    PH_XM,
    PH_NUM_CB,
    PH_SEMI1,
    PH_NUM_CX,
    PH_SEMI2,
    PH_NUM_CY,
    PH_FINAL,
    PH_X_CB,
    PH_X_CX,
    PH_X_CY
  } phase_t;

  localparam logic [7:0] CHR_ESC      = 8'h1B;
  localparam logic [7:0] CHR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHR_LT       = 8'h3C;
  localparam logic [7:0] CHR_SEMI     = 8'h3B;
  localparam logic [7:0] CHR_UPPER_M  = 8'h4D;
  localparam logic [7:0] CHR_LOWER_M  = 8'h6D;
  localparam logic [7:0] CHR_ZERO     = 8'h30;
  localparam logic [7:0] X10_BIAS     = 8'd32;

  localparam logic [6:0]       BTN_RELEASE = 7'd3;
  localparam logic [NUM_W-1:0] MAX_COORD   = 13'd4094;
  localparam logic [11:0]      X10_LIMIT   = 12'd222;

  // One classified event: values are final (Cb with modifiers, 1-based coords),
  // *_top is the index of the leading decimal place (3 = thousands).
  typedef struct packed {
    logic             sgr;
    logic             pressed;
    logic [6:0]       cb;
    logic [NUM_W-1:0] cx;
    logic [NUM_W-1:0] cy;
    logic [1:0]       cb_top;
    logic [1:0]       cx_top;
    logic [1:0]       cy_top;
  } item_t;

endpackage

// File: sv/mouse_report_encoder.sv
// Mouse report encoder: X10 and SGR escape sequences, one byte per cycle unless a waiting byte is not popped.
// The first byte of an event passes the queue, the sequencer state and the output register.
// The byte sequencer emits one byte per cycle unless a waiting byte is not popped;
// queued events follow without gaps.
// Dropped events (reporting off or reserved mode, X10 coordinate overflow) are never queued.
// Reset (rst, synchronous): mode off, queue and output empty.
module mouse_report_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        mouse_mode_we,
  input  logic [1:0]  mouse_mode_data,
  input  logic        push,
  output logic        full,
  input  logic [6:0]  button,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic        pressed,
  input  logic [2:0]  modifiers,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last
);
  import mre_pkg::*;

  logic [1:0] mouse_mode;
  item_t      f_item;
  logic       f_keep;
  item_t      q_item;
  logic       q_empty;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_mode <= MODE_OFF;
    end else if (mouse_mode_we) begin
      mouse_mode <= mouse_mode_data;
    end
  end

  mre_front u_front (
    .mode      (mouse_mode),
    .button    (button),
    .col       (col),
    .row       (row),
    .pressed   (pressed),
    .modifiers (modifiers),
    .item      (f_item),
    .keep      (f_keep)
  );

  mre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && f_keep),
    .wdata (f_item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  mre_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .item_in  (q_item),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last)
  );

endmodule

// File: sv/mre_front.sv
// Front end: classifies a mouse event into a report descriptor.
// Depends on mre_pkg.
module mre_front (
  input  logic [1:0]           mode,
  input  logic [6:0]           button,
  input  logic [11:0]          col,
  input  logic [11:0]          row,
  input  logic                 pressed,
  input  logic [2:0]           modifiers,
  output mre_pkg::item_t       item,
  output logic                 keep
);
  import mre_pkg::*;

  function automatic logic [1:0] top_place(input logic [NUM_W-1:0] v);
    logic [1:0] t;
    if (v >= NUM_W'(1000)) t = 2'd3;
    else if (v >= NUM_W'(100)) t = 2'd2;
    else if (v >= NUM_W'(10)) t = 2'd1;
    else t = 2'd0;
    return t;
  endfunction

  logic [6:0]       cb;
  logic             sgr;
  logic [NUM_W-1:0] col_sat;
  logic [NUM_W-1:0] row_sat;
  logic [NUM_W-1:0] cx;
  logic [NUM_W-1:0] cy;

  always_comb begin
    cb = button;
    if (!pressed && (button < BTN_RELEASE)) begin
      cb = BTN_RELEASE;
    end
    cb = cb | {2'b00, modifiers, 2'b00};

    sgr = (mode == MODE_SGR);
    col_sat = ({1'b0, col} > MAX_COORD) ? MAX_COORD : {1'b0, col};
    row_sat = ({1'b0, row} > MAX_COORD) ? MAX_COORD : {1'b0, row};
    cx = sgr ? col_sat + 1'b1 : {1'b0, col} + 1'b1;
    cy = sgr ? row_sat + 1'b1 : {1'b0, row} + 1'b1;

    item.sgr     = sgr;
    item.pressed = pressed;
    item.cb      = cb;
    item.cx      = cx;
    item.cy      = cy;
    item.cb_top  = top_place({{(NUM_W-7){1'b0}}, cb});
    item.cx_top  = top_place(cx);
    item.cy_top  = top_place(cy);

    keep = sgr || ((mode == MODE_X10) && (col <= X10_LIMIT) && (row <= X10_LIMIT));
  end

endmodule

// File: sv/mre_queue.sv
// Short request queue between front and back end.
// Depends on mre_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mre_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mre_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output mre_pkg::item_t rdata,
  output logic           empty
);
  import mre_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_cnt_range, cnt <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// File: sv/mre_back.sv
// Back end: sequences the report bytes into the output register, one per cycle unless a waiting byte is not popped.
// Depends on mre_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mre_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mre_pkg::item_t item_in,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           last
);
  import mre_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  phase_t           step_phase;
  item_t            cur;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_next;
  logic [1:0]       pidx;
  logic [1:0]       pidx_next;
  logic             out_valid;
  logic             adv;
  logic             emit;
  logic             load;
  logic [7:0]       byte_val;
  logic             byte_last;
  logic [NUM_W:0]   pl;
  logic [NUM_W:0]   mult [10];
  logic [3:0]       digit;
  logic [NUM_W-1:0] rem;
  logic             in_num;
  logic             x10_phase;

  // one decimal digit per cycle while the sequencer advances
  always_comb begin
    case (pidx)
      2'd0:    pl = (NUM_W+1)'(1);
      2'd1:    pl = (NUM_W+1)'(10);
      2'd2:    pl = (NUM_W+1)'(100);
      default: pl = (NUM_W+1)'(1000);
    endcase
    digit = '0;
    for (int k = 0; k < 10; k++) begin
      mult[k] = (NUM_W+1)'(pl * (NUM_W+1)'(k));
    end
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, num} >= mult[k]) begin
        digit = digit + 4'd1;
      end
    end
    rem = NUM_W'({1'b0, num} - mult[digit]);
  end

  assign in_num = (phase == PH_NUM_CB) || (phase == PH_NUM_CX) || (phase == PH_NUM_CY);
  assign x10_phase = (phase == PH_ESC) || (phase == PH_LBRACKET) || (phase == PH_XM) ||
                     (phase == PH_X_CB) || (phase == PH_X_CX) || (phase == PH_X_CY);
  assign adv    = !out_valid || pop;
  assign emit   = (phase != PH_IDLE) && adv;
  assign load   = !q_empty && ((phase == PH_IDLE) || (emit && byte_last));
  assign q_pop  = load;
  assign empty  = !out_valid;

  always_comb begin
    byte_val   = CHR_ESC;
    byte_last  = 1'b0;
    step_phase = phase;
    num_next   = num;
    pidx_next  = pidx;
    case (phase)
      PH_IDLE: begin
        step_phase = PH_IDLE;
      end
      PH_ESC: begin
        byte_val   = CHR_ESC;
        step_phase = PH_LBRACKET;
      end
      PH_LBRACKET: begin
        byte_val   = CHR_LBRACKET;
        step_phase = cur.sgr ? PH_LT : PH_XM;
      end
      PH_LT: begin
        byte_val   = CHR_LT;
        step_phase = PH_NUM_CB;
        num_next   = {{(NUM_W-7){1'b0}}, cur.cb};
        pidx_next  = cur.cb_top;
      end
      PH_XM: begin
        byte_val   = CHR_UPPER_M;
        step_phase = PH_X_CB;
      end
      PH_NUM_CB, PH_NUM_CX, PH_NUM_CY: begin
        byte_val  = CHR_ZERO + {4'b0000, digit};
        num_next  = rem;
        pidx_next = pidx - 1'b1;
        if (pidx == 2'd0) begin
          if (phase == PH_NUM_CB) step_phase = PH_SEMI1;
          else if (phase == PH_NUM_CX) step_phase = PH_SEMI2;
          else step_phase = PH_FINAL;
        end
      end
      PH_SEMI1: begin
        byte_val   = CHR_SEMI;
        step_phase = PH_NUM_CX;
        num_next   = cur.cx;
        pidx_next  = cur.cx_top;
      end
      PH_SEMI2: begin
        byte_val   = CHR_SEMI;
        step_phase = PH_NUM_CY;
        num_next   = cur.cy;
        pidx_next  = cur.cy_top;
      end
      PH_FINAL: begin
        byte_val   = cur.pressed ? CHR_UPPER_M : CHR_LOWER_M;
        byte_last  = 1'b1;
        step_phase = PH_IDLE;
      end
      PH_X_CB: begin
        byte_val   = X10_BIAS + {1'b0, cur.cb};
        step_phase = PH_X_CX;
      end
      PH_X_CX: begin
        byte_val   = X10_BIAS + cur.cx[7:0];
        step_phase = PH_X_CY;
      end
      PH_X_CY: begin
        byte_val   = X10_BIAS + cur.cy[7:0];
        byte_last  = 1'b1;
        step_phase = PH_IDLE;
      end
      default: begin
        step_phase = PH_IDLE;
      end
    endcase

    if (load) begin
      phase_next = PH_ESC;
    end else if (emit) begin
      phase_next = step_phase;
    end else begin
      phase_next = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= item_in;
    end
    if (emit) begin
      num  <= num_next;
      pidx <= pidx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_val;
      last     <= byte_last;
    end
  end

  `ASSERT_IMPL(a_digit_range, in_num, rem < pl, "decimal remainder not below place value")
  `ASSERT_IMPL(a_x10_phase, (phase != PH_IDLE) && !cur.sgr, x10_phase, "X10 report in SGR phase")

endmodule

// File: sim/tb.sv
// Testbench for mouse_report_encoder: X10 and SGR mouse escape sequences, one byte per pop.
// Uses mre_pkg for the mode codes and character constants; a local predictor checks every byte.
`timescale 1ns / 100ps

module tb;
  import mre_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [6:0]  button;
    logic [11:0] col;
    logic [11:0] row;
    logic        pressed;
    logic [2:0]  mods;
  } mouse_event_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } report_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        mouse_mode_we = 1'b0;
  logic [1:0]  mouse_mode_data = MODE_OFF;
  logic        push = 1'b0;
  logic        full;
  logic [6:0]  button = '0;
  logic [11:0] col = '0;
  logic [11:0] row = '0;
  logic        pressed = 1'b0;
  logic [2:0]  modifiers = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  mode_t          cur_mode = MODE_OFF;
  mouse_event_t   pending_events[$];
  report_byte_t   expected_bytes[$];
  int             events_queued = 0;
  int             events_taken = 0;
  int             err_count = 0;
  int             cycle_count = 0;
  int             rx_hold_req = 0;
  bit             no_gaps = 1'b0;
  logic           req_taken = 1'b0;

  mouse_report_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .mouse_mode_we  (mouse_mode_we),
    .mouse_mode_data(mouse_mode_data),
    .push           (push),
    .full           (full),
    .button         (button),
    .col            (col),
    .row            (row),
    .pressed        (pressed),
    .modifiers      (modifiers),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .last           (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               expected_bytes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic void push_byte(logic [7:0] b);
    expected_bytes.push_back('{value: b, last: 1'b0});
  endfunction

  function automatic void push_decimal(int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(8'(CHR_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) push_byte(digits[i]);
  endfunction

  function automatic void predict_report(mouse_event_t ev);
    logic [7:0]  cb;
    int unsigned cx;
    int unsigned cy;
    if (cur_mode != MODE_X10 && cur_mode != MODE_SGR) return;
    cb = {1'b0, ev.button};
    if (!ev.pressed && ev.button < BTN_RELEASE) cb = {1'b0, BTN_RELEASE};
    cb |= {3'b000, ev.mods, 2'b00};
    if (cur_mode == MODE_SGR) begin
      cx = (ev.col > MAX_COORD) ? MAX_COORD : ev.col;
      cy = (ev.row > MAX_COORD) ? MAX_COORD : ev.row;
      push_byte(CHR_ESC);
      push_byte(CHR_LBRACKET);
      push_byte(CHR_LT);
      push_decimal(cb);
      push_byte(CHR_SEMI);
      push_decimal(cx + 1);
      push_byte(CHR_SEMI);
      push_decimal(cy + 1);
      push_byte(ev.pressed ? CHR_UPPER_M : CHR_LOWER_M);
    end else begin
      if (ev.col > X10_LIMIT || ev.row > X10_LIMIT) return;
      push_byte(CHR_ESC);
      push_byte(CHR_LBRACKET);
      push_byte(CHR_UPPER_M);
      push_byte(8'(X10_BIAS + cb));
      push_byte(8'(X10_BIAS + 1 + ev.col));
      push_byte(8'(X10_BIAS + 1 + ev.row));
    end
    expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  // ---------------- check outputs, then record accepted requests ----------------
  always @(posedge clk) begin : check_and_predict
    report_byte_t want;
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected byte %h last %b at cycle %0d", out_byte, last, cycle_count);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.value || last !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch at cycle %0d: byte exp %h got %h, last exp %b got %b",
                     cycle_count, want.value, out_byte, want.last, last);
        end
      end
    end
    if (!rst && push && !full) begin
      predict_report('{button: button, col: col, row: row, pressed: pressed,
                       mods: modifiers});
      events_taken++;
    end
    req_taken <= !rst && push && !full;
  end

  // ---------------- request driver ----------------
  always @(negedge clk) begin : driver
    mouse_event_t ev;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      if (pending_events.size() != 0 && (no_gaps || $urandom_range(99) >= 27)) begin
        ev = pending_events.pop_front();
        button    <= ev.button;
        col       <= ev.col;
        row       <= ev.row;
        pressed   <= ev.pressed;
        modifiers <= ev.mods;
        push      <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------- result receiver ----------------
  always @(negedge clk) begin : receiver
    int hold_seen;
    int hold_left;
    if (rx_hold_req != hold_seen) begin
      hold_seen = rx_hold_req;
      hold_left = RX_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= no_gaps || ($urandom_range(99) >= 27);
    end
  end

  // ---------------- stimulus ----------------
  function automatic mouse_event_t make_event(int b, int c, int r, bit p, int m);
    return '{button: 7'(b), col: 12'(c), row: 12'(r), pressed: p, mods: 3'(m)};
  endfunction

  function automatic logic [11:0] rand_coord(bit fit_x10);
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3, 4, 5: return fit_x10 ? 12'($urandom_range(222)) : 12'($urandom_range(999));
      6: return fit_x10 ? 12'($urandom_range(223, 220)) : 12'($urandom_range(99, 8));
      7: return 12'($urandom_range(4095, 4090));
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  function automatic mouse_event_t rand_event(bit fit_x10);
    mouse_event_t ev;
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) ev.button = 7'($urandom_range(3));
    else if (sel < 7) ev.button = 7'(64 + $urandom_range(1));
    else ev.button = 7'($urandom_range(127));
    ev.col = rand_coord(fit_x10);
    ev.row = rand_coord(fit_x10);
    ev.pressed = 1'($urandom_range(1));
    ev.mods = 3'($urandom_range(7));
    return ev;
  endfunction

  task automatic queue_event(mouse_event_t ev);
    pending_events.push_back(ev);
    events_queued++;
  endtask

  task automatic queue_random(int n, bit fit_x10);
    repeat (n) queue_event(rand_event(fit_x10));
  endtask

  task automatic drain();
    while (events_taken != events_queued || expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic set_mode(mode_t m);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    mouse_mode_we   <= 1'b1;
    mouse_mode_data <= m;
    cur_mode = m;
    @(negedge clk);
    mouse_mode_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value: reporting off
    queue_event(make_event(0, 0, 0, 1, 0));
    queue_event(make_event(127, 4095, 4095, 0, 7));
    queue_random(8, 1'b0);

    set_mode(MODE_SGR);
    queue_event(make_event(0, 0, 0, 1, 0));
    queue_event(make_event(1, 8, 9, 1, 1));
    queue_event(make_event(2, 98, 99, 1, 2));
    queue_event(make_event(0, 998, 999, 0, 4));
    queue_event(make_event(2, 4093, 4094, 0, 7));
    queue_event(make_event(3, 4095, 4095, 1, 0));
    queue_event(make_event(3, 5, 6, 0, 0));
    queue_event(make_event(64, 9, 98, 1, 3));
    queue_event(make_event(65, 1, 1, 0, 5));
    queue_event(make_event(127, 4094, 0, 1, 7));
    queue_event(make_event(100, 12, 4095, 0, 6));
    drain();
    rx_hold_req++;
    queue_random(120, 1'b0);
    drain();
    queue_random(40, 1'b0);

    set_mode(MODE_X10);
    queue_event(make_event(0, 0, 0, 1, 0));
    queue_event(make_event(127, 222, 222, 1, 7));
    queue_event(make_event(1, 223, 0, 0, 0));
    queue_event(make_event(2, 0, 223, 1, 0));
    queue_event(make_event(64, 100, 4095, 1, 0));
    queue_event(make_event(65, 221, 5, 0, 6));
    queue_event(make_event(2, 10, 10, 0, 1));
    queue_random(120, 1'b1);

    set_mode(MODE_RSV);
    queue_event(make_event(0, 0, 0, 1, 0));
    queue_event(make_event(1, 10, 10, 0, 7));
    queue_random(8, 1'b1);

    set_mode(MODE_OFF);
    queue_random(8, 1'b1);

    set_mode(MODE_X10);
    no_gaps = 1'b1;
    queue_random(40, 1'b1);
    drain();
    no_gaps = 1'b0;

    set_mode(MODE_SGR);
    queue_random(44, 1'b0);

    drain();
    repeat (20) @(negedge clk);
    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d bytes outstanding", err_count, expected_bytes.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
